@@ rtl/shmb_pkg.sv @@
package shmb_pkg;

    // Filter window
    localparam int WINDOW = 5;
    localparam int IDX_W  = 3;

    // Configuration registers
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIB_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE = 2'd2;
    localparam logic [CFG_W-1:0] CALIB_THR_RST = 10'd20;
    localparam logic [CFG_W-1:0] MIN_RANGE_RST = 10'd30;
    localparam logic [CFG_W-1:0] MAX_RANGE_RST = 10'd350;

    // Datapath widths
    localparam int RANGE_W = 11;
    localparam int Z_W     = 16;
    localparam int OFF_W   = Z_W + 1;
    localparam int D_W     = 18;
    localparam int S_W     = 19;
    localparam int P_W     = D_W + S_W;
    localparam int MAG_W   = 32;
    localparam int Q_W     = 22;
    localparam int H_W     = 21;

    // Blend divisor and its reciprocal: floor(2^RECIP_SHIFT / BLEND_SPAN)
    localparam int BLEND_SPAN  = 1500;
    localparam int RECIP_SHIFT = 42;
    localparam logic [MAG_W-1:0] RECIP = 32'd2932031007;

    // Stream widths
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic                  calib;
        logic                  filt_ready;
        logic signed [D_W-1:0] data;
        logic signed [Z_W-1:0] z_est;
    } work_item_t;

endpackage

@@ rtl/shmb_front.sv @@
module shmb_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [shmb_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [shmb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [shmb_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 q_full,
    output logic                                 push,
    output shmb_pkg::work_item_t                 push_item
);

    logic [shmb_pkg::CFG_W-1:0] calib_thr_reg;
    logic [shmb_pkg::CFG_W-1:0] min_range_reg;
    logic [shmb_pkg::CFG_W-1:0] max_range_reg;

    logic signed [shmb_pkg::OFF_W-1:0] offset_reg;
    logic signed [shmb_pkg::OFF_W-1:0] offset_next;
    logic                              calib_pending_reg;
    logic                              calib_pending_next;
    logic [shmb_pkg::IDX_W-1:0]        ring_idx_reg;
    logic [shmb_pkg::IDX_W-1:0]        ring_idx_next;
    logic                              window_full_reg;
    logic                              window_full_next;
    logic signed [shmb_pkg::D_W-1:0]   ring_reg  [shmb_pkg::WINDOW];
    logic signed [shmb_pkg::D_W-1:0]   ring_next [shmb_pkg::WINDOW];

    logic                                accept;
    logic signed [shmb_pkg::RANGE_W-1:0] range_w;
    logic signed [shmb_pkg::Z_W-1:0]     z_w;
    logic [shmb_pkg::Z_W:0]              z_x;
    logic [shmb_pkg::Z_W:0]              z_neg;
    logic [shmb_pkg::Z_W:0]              z_mag;
    logic                                calib_hit;
    logic signed [shmb_pkg::RANGE_W-1:0] min_s;
    logic signed [shmb_pkg::RANGE_W-1:0] max_s;
    logic signed [shmb_pkg::RANGE_W-1:0] r_clamp;
    logic signed [shmb_pkg::D_W-1:0]     sample;
    logic                                store;
    logic signed [shmb_pkg::D_W-1:0]     med;

    // Median of five: fixed seven-exchange network
    function automatic logic signed [shmb_pkg::D_W-1:0] median5(
        input logic signed [shmb_pkg::D_W-1:0] v0,
        input logic signed [shmb_pkg::D_W-1:0] v1,
        input logic signed [shmb_pkg::D_W-1:0] v2,
        input logic signed [shmb_pkg::D_W-1:0] v3,
        input logic signed [shmb_pkg::D_W-1:0] v4
    );
        logic signed [shmb_pkg::D_W-1:0] p0;
        logic signed [shmb_pkg::D_W-1:0] p1;
        logic signed [shmb_pkg::D_W-1:0] p2;
        logic signed [shmb_pkg::D_W-1:0] p3;
        logic signed [shmb_pkg::D_W-1:0] p4;
        logic signed [shmb_pkg::D_W-1:0] t;
        p0 = v0;
        p1 = v1;
        p2 = v2;
        p3 = v3;
        p4 = v4;
        if (p0 > p1)
        begin
            t = p0; p0 = p1; p1 = t;
        end
        if (p3 > p4)
        begin
            t = p3; p3 = p4; p4 = t;
        end
        if (p0 > p3)
        begin
            t = p0; p0 = p3; p3 = t;
        end
        if (p1 > p4)
        begin
            t = p1; p1 = p4; p4 = t;
        end
        if (p1 > p2)
        begin
            t = p1; p1 = p2; p2 = t;
        end
        if (p2 > p3)
        begin
            t = p2; p2 = p3; p3 = t;
        end
        if (p1 > p2)
        begin
            t = p1; p1 = p2; p2 = t;
        end
        return p2;
    endfunction

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;
    assign cfg_ready     = 1'b1;

    assign range_w = s_axis_tdata[shmb_pkg::RANGE_W-1:0];
    assign z_w     = s_axis_tdata[shmb_pkg::RANGE_W +: shmb_pkg::Z_W];

    // Calibration trigger on |z|
    assign z_x       = {z_w[shmb_pkg::Z_W-1], z_w};
    assign z_neg     = ~z_x + 1'b1;
    assign z_mag     = z_x[shmb_pkg::Z_W] ? z_neg : z_x;
    assign calib_hit = z_mag > {{(shmb_pkg::Z_W + 1 - shmb_pkg::CFG_W){1'b0}}, calib_thr_reg};

    // Clamp: upper bound tested first, so it wins when bounds cross and the range exceeds it
    assign min_s = {1'b0, min_range_reg};
    assign max_s = {1'b0, max_range_reg};

    always_comb
    begin
        if (range_w > max_s)
            r_clamp = max_s;
        else if (range_w < min_s)
            r_clamp = min_s;
        else
            r_clamp = range_w;
    end

    assign sample = {{(shmb_pkg::D_W - shmb_pkg::RANGE_W){r_clamp[shmb_pkg::RANGE_W-1]}}, r_clamp}
                  + {offset_reg[shmb_pkg::OFF_W-1], offset_reg};
    assign store  = !calib_pending_reg && !sample[shmb_pkg::D_W-1];

    always_comb
    begin
        offset_next        = offset_reg;
        calib_pending_next = calib_pending_reg;
        ring_idx_next      = ring_idx_reg;
        window_full_next   = window_full_reg;
        if (calib_pending_reg)
        begin
            if (calib_hit)
            begin
                offset_next = z_neg - {{(shmb_pkg::OFF_W - shmb_pkg::RANGE_W){range_w[shmb_pkg::RANGE_W-1]}},
                                        range_w};
                calib_pending_next = 1'b0;
            end
        end
        else if (store)
        begin
            if (ring_idx_reg == shmb_pkg::IDX_W'(shmb_pkg::WINDOW - 1))
            begin
                ring_idx_next    = '0;
                window_full_next = 1'b1;
            end
            else
                ring_idx_next = ring_idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        for (int k = 0; k < shmb_pkg::WINDOW; k++)
        begin
            if (store && ring_idx_reg == shmb_pkg::IDX_W'(k))
                ring_next[k] = sample;
            else
                ring_next[k] = ring_reg[k];
        end
    end

    assign med = median5(ring_next[0], ring_next[1], ring_next[2], ring_next[3], ring_next[4]);

    assign push                 = accept;
    assign push_item.calib      = calib_pending_reg;
    assign push_item.filt_ready = window_full_next;
    assign push_item.data       = window_full_next ? med : sample;
    assign push_item.z_est      = z_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_thr_reg <= shmb_pkg::CALIB_THR_RST;
            min_range_reg <= shmb_pkg::MIN_RANGE_RST;
            max_range_reg <= shmb_pkg::MAX_RANGE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                shmb_pkg::CFG_CALIB_THR: calib_thr_reg <= cfg_data;
                shmb_pkg::CFG_MIN_RANGE: min_range_reg <= cfg_data;
                shmb_pkg::CFG_MAX_RANGE: max_range_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg        <= '0;
            calib_pending_reg <= 1'b1;
            ring_idx_reg      <= '0;
            window_full_reg   <= 1'b0;
        end
        else if (accept)
        begin
            offset_reg        <= offset_next;
            calib_pending_reg <= calib_pending_next;
            ring_idx_reg      <= ring_idx_next;
            window_full_reg   <= window_full_next;
        end
    end

    // Sample ring: payload only, guarded by window_full_next
    always_ff @(posedge clk)
    begin
        if (accept && store)
            ring_reg[ring_idx_reg] <= sample;
    end

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        ring_idx_reg < shmb_pkg::IDX_W'(shmb_pkg::WINDOW))
        else $error("ring index out of window");

    a_calib_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !calib_pending_reg |=> !calib_pending_reg)
        else $error("calibration re-entered");

endmodule

@@ rtl/shmb_queue.sv @@
module shmb_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  shmb_pkg::work_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 empty,
    output shmb_pkg::work_item_t head
);

    shmb_pkg::work_item_t          mem_reg [shmb_pkg::QUEUE_DEPTH];
    logic [shmb_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [shmb_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [shmb_pkg::QCNT_W-1:0]   count_reg;
    logic [shmb_pkg::QCNT_W-1:0]   count_next;

    assign full  = count_reg == shmb_pkg::QCNT_W'(shmb_pkg::QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

@@ rtl/shmb_back.sv @@
module shmb_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_empty,
    input  shmb_pkg::work_item_t                 q_head,
    output logic                                 q_pop,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [shmb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic [shmb_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);

    localparam logic [shmb_pkg::Q_W-1:0] POS_LIMIT = shmb_pkg::Q_W'((1 << (shmb_pkg::H_W - 1)) - 1);
    localparam logic [shmb_pkg::Q_W-1:0] NEG_LIMIT = shmb_pkg::Q_W'(1 << (shmb_pkg::H_W - 1));
    localparam logic [shmb_pkg::MAG_W-1:0] SPAN    = shmb_pkg::MAG_W'(shmb_pkg::BLEND_SPAN);
    localparam logic [shmb_pkg::MAG_W-1:0] SPAN2   = shmb_pkg::MAG_W'(2 * shmb_pkg::BLEND_SPAN);

    logic adv;

    // Stage A: product d * (z + d - span)
    logic                               a_valid_reg;
    logic                               a_calib_reg;
    logic                               a_filt_reg;
    logic signed [shmb_pkg::P_W-1:0]    a_prod_reg;
    logic signed [shmb_pkg::S_W-1:0]    s_w;
    logic signed [shmb_pkg::P_W-1:0]    d_x;
    logic signed [shmb_pkg::P_W-1:0]    s_x;
    logic signed [shmb_pkg::P_W-1:0]    prod_w;

    // Stage B: magnitude times reciprocal
    logic                               b_valid_reg;
    logic                               b_calib_reg;
    logic                               b_filt_reg;
    logic                               b_neg_reg;
    logic [shmb_pkg::MAG_W-1:0]         b_mag_reg;
    logic [shmb_pkg::Q_W-1:0]           b_q0_reg;
    logic [shmb_pkg::P_W-1:0]           prod_abs;
    logic [shmb_pkg::MAG_W-1:0]         mag_w;
    logic [2*shmb_pkg::MAG_W-1:0]       recip_prod;

    // Stage C: quotient correction
    logic                               c_valid_reg;
    logic                               c_calib_reg;
    logic                               c_filt_reg;
    logic                               c_neg_reg;
    logic [shmb_pkg::Q_W-1:0]           c_q_reg;
    logic [shmb_pkg::MAG_W-1:0]         q_span;
    logic [shmb_pkg::MAG_W-1:0]         rem_w;

    // Output stage: sign, saturation, hold while calibrating
    logic                               out_valid_reg;
    logic [shmb_pkg::H_W-1:0]           out_height_reg;
    logic                               out_calib_reg;
    logic                               out_filt_reg;
    logic [shmb_pkg::H_W-1:0]           last_height_reg;
    logic [shmb_pkg::Q_W-1:0]           neg_q;
    logic [shmb_pkg::H_W-1:0]           height_w;
    logic [shmb_pkg::H_W-1:0]           height_sel;

    assign adv   = !out_valid_reg || m_axis_tready;
    assign q_pop = adv && !q_empty;

    assign s_w    = {{(shmb_pkg::S_W - shmb_pkg::Z_W){q_head.z_est[shmb_pkg::Z_W-1]}}, q_head.z_est}
                  + {{(shmb_pkg::S_W - shmb_pkg::D_W){q_head.data[shmb_pkg::D_W-1]}}, q_head.data}
                  - shmb_pkg::S_W'(shmb_pkg::BLEND_SPAN);
    assign d_x    = {{(shmb_pkg::P_W - shmb_pkg::D_W){q_head.data[shmb_pkg::D_W-1]}}, q_head.data};
    assign s_x    = {{(shmb_pkg::P_W - shmb_pkg::S_W){s_w[shmb_pkg::S_W-1]}}, s_w};
    assign prod_w = d_x * s_x;

    // |product| stays below 2^32 over the whole input range
    assign prod_abs   = a_prod_reg[shmb_pkg::P_W-1] ? (~a_prod_reg + 1'b1) : a_prod_reg;
    assign mag_w      = prod_abs[shmb_pkg::MAG_W-1:0];
    assign recip_prod = {{shmb_pkg::MAG_W{1'b0}}, mag_w} * {{shmb_pkg::MAG_W{1'b0}}, shmb_pkg::RECIP};

    // Reciprocal estimate is exact or one low
    assign q_span = shmb_pkg::MAG_W'(b_q0_reg) * SPAN;
    assign rem_w  = b_mag_reg - q_span;

    assign neg_q = ~c_q_reg + 1'b1;

    always_comb
    begin
        if (c_neg_reg)
        begin
            if (c_q_reg > NEG_LIMIT)
                height_w = NEG_LIMIT[shmb_pkg::H_W-1:0];
            else
                height_w = neg_q[shmb_pkg::H_W-1:0];
        end
        else
        begin
            if (c_q_reg > POS_LIMIT)
                height_w = POS_LIMIT[shmb_pkg::H_W-1:0];
            else
                height_w = c_q_reg[shmb_pkg::H_W-1:0];
        end
    end

    assign height_sel = c_calib_reg ? last_height_reg : height_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
            c_valid_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            last_height_reg <= '0;
        end
        else if (adv)
        begin
            a_valid_reg   <= !q_empty;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            out_valid_reg <= c_valid_reg;
            if (c_valid_reg && !c_calib_reg)
                last_height_reg <= height_w;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_calib_reg    <= q_head.calib;
            a_filt_reg     <= q_head.filt_ready;
            a_prod_reg     <= prod_w;

            b_calib_reg    <= a_calib_reg;
            b_filt_reg     <= a_filt_reg;
            b_neg_reg      <= a_prod_reg[shmb_pkg::P_W-1];
            b_mag_reg      <= mag_w;
            b_q0_reg       <= recip_prod[shmb_pkg::RECIP_SHIFT +: shmb_pkg::Q_W];

            c_calib_reg    <= b_calib_reg;
            c_filt_reg     <= b_filt_reg;
            c_neg_reg      <= b_neg_reg;
            c_q_reg        <= (rem_w >= SPAN) ? b_q0_reg + 1'b1 : b_q0_reg;

            out_height_reg <= height_sel;
            out_calib_reg  <= c_calib_reg;
            out_filt_reg   <= c_filt_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(shmb_pkg::OUT_TDATA_W - shmb_pkg::H_W){1'b0}}, out_height_reg};
    assign m_axis_tuser  = {out_filt_reg, out_calib_reg};

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> rem_w < SPAN2)
        else $error("reciprocal estimate off by more than one");

    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg |-> !c_q_reg[shmb_pkg::Q_W-1])
        else $error("quotient exceeds expected range");

endmodule

@@ rtl/sonar_height_median_blend_top.sv @@
// Sonar height filter. Each input item carries a sonar range and a vertical position
// estimate (cm, negative is up); each produces exactly one result item, in order. Until
// |z| exceeds calib_threshold_cm the block calibrates: it reports the held height (zero
// after reset) with calibrating set, and on the trigger item captures
// offset = -z - range. After that the range is clamped to [min_range_cm, max_range_cm]
// (upper bound tested first), the offset is added, non-negative samples enter a
// five-entry ring, and once the ring has filled the median of the ring replaces the
// sample. The result is trunc(d * (z + d - 1500) / 1500), saturated to 21 bits signed.
// Throughput is one item per clock while the queue has room and the sink is ready: the
// offset, ring and median network update within the accepting cycle, and the blend runs
// in a four-stage pipeline (multiply, reciprocal multiply, quotient correction, saturate
// into the output register) fed from the queue. A four-item queue sits between the
// classifying front and the arithmetic back, so input stays open while a result waits.
// Configuration writes are always ready and should be issued while the block is idle.
// The sample ring needs no clearing after reset.
module sonar_height_median_blend_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // tdata: [10:0] range_cm, [26:11] z_est_cm, [31:27] zero
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [shmb_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // tdata: [20:0] height_cm, [23:21] zero
    // tuser: [0] calibrating, [1] filter_ready
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [shmb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic [shmb_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
    // index 0 calib_threshold_cm, 1 min_range_cm, 2 max_range_cm
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [shmb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [shmb_pkg::CFG_W-1:0]           cfg_data
);

    logic                 q_full;
    logic                 q_empty;
    logic                 push;
    logic                 pop;
    shmb_pkg::work_item_t push_item;
    shmb_pkg::work_item_t head;

    // Front: accept, calibrate, clamp, ring update and median
    shmb_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_full        (q_full),
        .push          (push),
        .push_item     (push_item)
    );

    // Decoupling queue
    shmb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .head      (head)
    );

    // Back: blend arithmetic and output register
    shmb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_head        (head),
        .q_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

@@ verif/sonar_height_median_blend_top_tb.sv @@
module sonar_height_median_blend_top_tb;

    // Run shape
    localparam int CYCLE_LIMIT       = 400000;  // far above the slowest correct run
    localparam int N_ROWS            = 22;      // directed rows
    localparam int N_SETTINGS        = 6;       // register settings, two per pacing phase
    localparam int ITEMS_PER_SETTING = 100;
    localparam int HOLD_OFF_CYCLES   = 80;      // long sink stall: fills queue and pipeline
    localparam int TAIL_CYCLES       = 20;      // well past the queue and pipeline latency
    localparam int MAX_PRINTS        = 40;

    // Index past the register list; the block must drop the write
    localparam logic [shmb_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    localparam longint HEIGHT_TOP = 1048575;
    localparam longint HEIGHT_BOT = -1048576;

    typedef struct {
        logic signed [shmb_pkg::H_W-1:0] height;
        logic                            calib;
        logic                            ready;
    } height_result_t;

    // Directed row; fixed_exp marks rows whose result is typed in
    typedef struct {
        int rng;
        int z;
        bit fixed_exp;
        int height;
        bit calib;
        bit ready;
    } stim_row_t;

    typedef struct {
        int thr;
        int min_r;
        int max_r;
    } range_setting_t;

    logic                             clk;
    logic                             rst_n          = 1'b0;
    logic                             s_axis_tvalid  = 1'b0;
    logic                             s_axis_tready;
    logic [shmb_pkg::IN_TDATA_W-1:0]  s_axis_tdata   = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready  = 1'b0;
    logic [shmb_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [shmb_pkg::OUT_TUSER_W-1:0] m_axis_tuser;
    logic                             cfg_valid      = 1'b0;
    logic                             cfg_ready;
    logic [shmb_pkg::CFG_IDX_W-1:0]   cfg_index      = '0;
    logic [shmb_pkg::CFG_W-1:0]       cfg_data       = '0;

    // Pacing knobs, set by the stimulus process
    int send_gap_pct = 0;
    int recv_gap_pct = 0;
    int hold_left    = 0;

    int mismatch_count = 0;
    int result_count   = 0;
    int cycle_count    = 0;

    // Heights still owed by the block, oldest first
    height_result_t height_q [$];

    // Predictor copy of the block state and registers
    int  thr_cfg = int'(shmb_pkg::CALIB_THR_RST);
    int  min_cfg = int'(shmb_pkg::MIN_RANGE_RST);
    int  max_cfg = int'(shmb_pkg::MAX_RANGE_RST);
    int  blend_offset = 0;
    bit  calib_wait   = 1'b1;
    int  sample_hist [shmb_pkg::WINDOW];
    int  hist_pos     = 0;
    bit  hist_full    = 1'b0;
    int  held_height  = 0;

    sonar_height_median_blend_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // One compare-swap of the median network
    function automatic void sort2(inout int a, inout int b);
        int t;
        if (a > b)
        begin
            t = a;
            a = b;
            b = t;
        end
    endfunction

    // Advances the predictor by one accepted item and returns the result it owes.
    function automatic height_result_t predict_height(input int rng, input int z);
        height_result_t res;
        int     r;
        int     d;
        int     mag;
        int     p [shmb_pkg::WINDOW];
        longint h;
        res.calib = calib_wait;
        if (calib_wait)
        begin
            // Capture tick: offset latched, height held, filtering from next item on
            mag = (z < 0) ? -z : z;
            if (mag > thr_cfg)
            begin
                blend_offset = -z - rng;
                calib_wait   = 1'b0;
            end
        end
        else
        begin
            // Upper bound is tested first; it wins when the bounds are crossed and r exceeds it
            r = rng;
            if (r > max_cfg)
                r = max_cfg;
            else if (r < min_cfg)
                r = min_cfg;
            d = r + blend_offset;
            // Negative samples bypass the ring
            if (d >= 0)
            begin
                sample_hist[hist_pos] = d;
                hist_pos++;
                if (hist_pos >= shmb_pkg::WINDOW)
                begin
                    hist_pos  = 0;
                    hist_full = 1'b1;
                end
            end
            if (hist_full)
            begin
                p = sample_hist;
                sort2(p[0], p[1]);
                sort2(p[3], p[4]);
                sort2(p[0], p[3]);
                sort2(p[1], p[4]);
                sort2(p[1], p[2]);
                sort2(p[2], p[3]);
                sort2(p[1], p[2]);
                d = p[2];
            end
            h = longint'(d) * (longint'(z) + longint'(d) - longint'(shmb_pkg::BLEND_SPAN));
            h = h / shmb_pkg::BLEND_SPAN;   // truncates toward zero
            if (h > HEIGHT_TOP)
                h = HEIGHT_TOP;
            if (h < HEIGHT_BOT)
                h = HEIGHT_BOT;
            held_height = int'(h);
        end
        res.height = held_height[shmb_pkg::H_W-1:0];
        res.ready  = hist_full;
        return res;
    endfunction

    task automatic flag_mismatch(input string field, input longint got, input longint want);
        if (mismatch_count < MAX_PRINTS)
            $display("result %0d: %s got %0d want %0d", result_count, field, got, want);
        mismatch_count++;
    endtask

    // Register write; valid drops for one cycle after each write so that
    // back-to-back writes never assign valid twice in one step.
    task automatic cfg_write(input logic [shmb_pkg::CFG_IDX_W-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[shmb_pkg::CFG_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            shmb_pkg::CFG_CALIB_THR: thr_cfg = int'(val[shmb_pkg::CFG_W-1:0]);
            shmb_pkg::CFG_MIN_RANGE: min_cfg = int'(val[shmb_pkg::CFG_W-1:0]);
            shmb_pkg::CFG_MAX_RANGE: max_cfg = int'(val[shmb_pkg::CFG_W-1:0]);
            default: ;
        endcase
    endtask

    // Offers one item, with random gaps ahead of it; returns in the step it was taken.
    task automatic send_item(input int rng, input int z);
        logic [shmb_pkg::RANGE_W-1:0] rb;
        logic [shmb_pkg::Z_W-1:0]     zb;
        rb = rng[shmb_pkg::RANGE_W-1:0];
        zb = z[shmb_pkg::Z_W-1:0];
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(shmb_pkg::IN_TDATA_W - shmb_pkg::RANGE_W - shmb_pkg::Z_W){1'b0}},
                          zb, rb};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Sender goes quiet until every owed result is back
    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        while (height_q.size() != 0)
            @(posedge clk);
    endtask

    // Sink pacing: a requested hold-off first, else random back-pressure
    initial
    begin : sink_pacing
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
            end
        end
    end

    // Each result item against the oldest owed result
    always @(posedge clk)
    begin : result_check
        height_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (height_q.size() == 0)
            begin
                flag_mismatch("item with nothing owed, height_cm",
                              longint'($signed(m_axis_tdata[shmb_pkg::H_W-1:0])), 0);
            end
            else
            begin
                want = height_q.pop_front();
                if (m_axis_tdata[shmb_pkg::H_W-1:0] !== want.height)
                    flag_mismatch("height_cm",
                                  longint'($signed(m_axis_tdata[shmb_pkg::H_W-1:0])),
                                  longint'(want.height));
                if (m_axis_tdata[shmb_pkg::OUT_TDATA_W-1:shmb_pkg::H_W] !== '0)
                    flag_mismatch("tdata pad",
                                  longint'(m_axis_tdata[shmb_pkg::OUT_TDATA_W-1:shmb_pkg::H_W]),
                                  0);
                if (m_axis_tuser[0] !== want.calib)
                    flag_mismatch("calibrating", longint'(m_axis_tuser[0]),
                                  longint'(want.calib));
                if (m_axis_tuser[1] !== want.ready)
                    flag_mismatch("filter_ready", longint'(m_axis_tuser[1]),
                                  longint'(want.ready));
            end
            result_count++;
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("sonar_height_median_blend_top: mismatch");
            $finish;
        end
    end

    initial
    begin : stimulus
        stim_row_t      rows [N_ROWS];
        range_setting_t settings [N_SETTINGS];
        height_result_t want;
        logic [31:0]    pick;
        int             rng_i;
        int             z_i;
        int             sel;
        int             k;
        int             n;
        int             ph;
        int             sub;

        // Rows 0..4 run while calibrating: held height zero, calibrating set.
        // Threshold is 1000 here, so |z| = 1000 must not trigger; row 4 does.
        // Post-capture rows walk clamps, negative samples before and after the
        // window fills, the zero-sample edge and the z extremes.
        rows = '{
            '{0,     0,      1'b1, 0, 1'b1, 1'b0},
            '{-1024, 1000,   1'b1, 0, 1'b1, 1'b0},
            '{1023,  -1000,  1'b1, 0, 1'b1, 1'b0},
            '{-1,    -1,     1'b1, 0, 1'b1, 1'b0},
            '{-801,  1001,   1'b1, 0, 1'b1, 1'b0},
            '{-1024, 0,      1'b0, 0, 1'b0, 1'b0},
            '{1023,  32767,  1'b0, 0, 1'b0, 1'b0},
            '{29,    -32768, 1'b0, 0, 1'b0, 1'b0},
            '{30,    -1,     1'b0, 0, 1'b0, 1'b0},
            '{350,   1500,   1'b0, 0, 1'b0, 1'b0},
            '{351,   0,      1'b0, 0, 1'b0, 1'b0},
            '{100,   200,    1'b0, 0, 1'b0, 1'b0},
            '{250,   -200,   1'b0, 0, 1'b0, 1'b0},
            '{300,   32767,  1'b0, 0, 1'b0, 1'b0},
            '{100,   0,      1'b0, 0, 1'b0, 1'b0},
            '{220,   -32768, 1'b0, 0, 1'b0, 1'b0},
            '{0,     1,      1'b0, 0, 1'b0, 1'b0},
            '{1023,  -32768, 1'b0, 0, 1'b0, 1'b0},
            '{-1024, 32767,  1'b0, 0, 1'b0, 1'b0},
            '{200,   1500,   1'b0, 0, 1'b0, 1'b0},
            '{199,   -1500,  1'b0, 0, 1'b0, 1'b0},
            '{345,   12345,  1'b0, 0, 1'b0, 1'b0}
        };
        // Offset is captured once per run. The usual capture gives offset -200
        // (negative samples reachable); one seed in four gives +28000 instead,
        // where large z drives the height into saturation.
        if ($urandom_range(0, 3) == 0)
        begin
            rows[4].rng = 0;
            rows[4].z   = -28000;
        end

        // Wide open, crossed, pinned, mid band, random, back to reset values
        settings = '{
            '{0,    0,    1023},
            '{1000, 1023, 0},
            '{20,   400,  400},
            '{500,  200,  700},
            '{0,    0,    0},
            '{int'(shmb_pkg::CALIB_THR_RST), int'(shmb_pkg::MIN_RANGE_RST),
              int'(shmb_pkg::MAX_RANGE_RST)}
        };
        settings[4].thr   = $urandom_range(0, 1000);
        settings[4].min_r = $urandom_range(0, 1023);
        settings[4].max_r = $urandom_range(0, 1023);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cfg_write(shmb_pkg::CFG_CALIB_THR, 1000);

        send_gap_pct = 25;
        recv_gap_pct = 70;
        for (k = 0; k < N_ROWS; k++)
        begin
            send_item(rows[k].rng, rows[k].z);
            want = predict_height(rows[k].rng, rows[k].z);
            if (rows[k].fixed_exp)
            begin
                want.height = rows[k].height[shmb_pkg::H_W-1:0];
                want.calib  = rows[k].calib;
                want.ready  = rows[k].ready;
            end
            height_q.push_back(want);
        end
        wait_results();

        // Phase 0: sender 25 / sink 70 idle, phase 1 swapped, phase 2 no idling
        for (ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_gap_pct = 25;
                    recv_gap_pct = 70;
                end
                1:
                begin
                    send_gap_pct = 70;
                    recv_gap_pct = 25;
                end
                default:
                begin
                    send_gap_pct = 0;
                    recv_gap_pct = 0;
                end
            endcase
            for (sub = 0; sub < 2; sub++)
            begin
                k = ph * 2 + sub;
                // Block is idle here: every owed result has come back
                cfg_write(shmb_pkg::CFG_CALIB_THR, settings[k].thr);
                cfg_write(shmb_pkg::CFG_MIN_RANGE, settings[k].min_r);
                cfg_write(shmb_pkg::CFG_MAX_RANGE, settings[k].max_r);
                if (k == 3)
                    cfg_write(CFG_SPARE_IDX, $urandom_range(0, 1023));
                for (n = 0; n < ITEMS_PER_SETTING; n++)
                begin
                    // Long sink stall while the sender keeps offering
                    if (ph == 2 && sub == 0 && n == 10)
                        hold_left = HOLD_OFF_CYCLES;

                    // Range: full 11-bit noise, in-band values, or near a bound
                    sel  = $urandom_range(0, 9);
                    pick = $urandom;
                    if (sel < 4)
                        rng_i = int'($signed(pick[shmb_pkg::RANGE_W-1:0]));
                    else if (sel < 7)
                        rng_i = $urandom_range(0, 1023);
                    else
                    begin
                        rng_i = (pick[31] ? min_cfg : max_cfg)
                                + int'($urandom_range(0, 4)) - 2;
                        if (rng_i > 1023)
                            rng_i = 1023;
                    end

                    // z: full 16-bit noise, small values, or extremes
                    sel  = $urandom_range(0, 9);
                    pick = $urandom;
                    if (sel < 5)
                        z_i = int'($signed(pick[shmb_pkg::Z_W-1:0]));
                    else if (sel < 8)
                        z_i = int'($urandom_range(0, 4000)) - 2000;
                    else
                    begin
                        case (pick[1:0])
                            2'd0:    z_i = -32768;
                            2'd1:    z_i = 32767;
                            2'd2:    z_i = 0;
                            default: z_i = shmb_pkg::BLEND_SPAN;
                        endcase
                    end

                    send_item(rng_i, z_i);
                    height_q.push_back(predict_height(rng_i, z_i));
                end
                wait_results();
            end
        end

        // Catch any stray result after the last owed one
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && height_q.size() == 0)
            $display("sonar_height_median_blend_top: match");
        else
            $display("sonar_height_median_blend_top: mismatch");
        $finish;
    end

endmodule
